/* hdl/hdx_pkg.sv */
// ----------------------------------------------------------------------------
// hdx_pkg
// Shared types and constants for the hex dump text extractor.
// ----------------------------------------------------------------------------
package hdx_pkg;

	localparam int ADDR_W         = 32;
	localparam int BYTES_W        = 17;
	localparam int MAX_DUMP_BYTES = 65536;
	localparam int ADDR_DIGITS_MAX = 8;
	localparam int DIGIT_CNT_W    = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 1'b1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_LAST      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_ADDR   = 2'd1,
		PH_LINE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       run_end;
	} result_t;

	typedef struct packed {
		logic [1:0] num;
		result_t    first;
		result_t    second;
	} res_pair_t;

endpackage

/* hdl/hdx_if.sv */
// ----------------------------------------------------------------------------
// hdx interfaces
// Valid/ready channels for text characters, results and register writes.
// ----------------------------------------------------------------------------
interface hdx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       final_req;

	modport source (output valid, output character, output final_req, input ready);
	modport sink (input valid, input character, input final_req, output ready);
endinterface

interface hdx_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic       run_end;

	modport source (output valid, output data_byte, output status, output run_end,
		input ready);
	modport sink (input valid, input data_byte, input status, input run_end,
		output ready);
endinterface

interface hdx_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hdx_pkg::CFG_IDX_W-1:0]  index;
	logic [hdx_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/hex_dump_text_extractor.sv */
// ----------------------------------------------------------------------------
// hex_dump_text_extractor
// Scans debug text for "0xADDR:" dump lines and extracts a run of bytes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  text     in   valid/ready   character[7:0], final_req
//  result   out  valid/ready   data_byte[7:0], status[1:0], run_end
//  cfg      in   valid/ready   index[0], data[31:0] (always ready)
//
//  one character a cycle while the queue has room: input register, parse, two-entry result queue
//  a character yields zero to two results, pushed into the queue as it leaves the input register
//  with the queue full the input register holds and text.ready drops
//  sustained rate is one character per cycle while results drain at that rate
//  arst_n clears the registers: start address 0, byte count 1, run armed
// ----------------------------------------------------------------------------
module hex_dump_text_extractor (
	input  logic            clk,
	input  logic            arst_n,
	hdx_char_if.sink        text,
	hdx_result_if.source    result,
	hdx_cfg_if.sink         cfg
);

	logic               room;
	logic               push;
	hdx_pkg::res_pair_t pair;
	hdx_pkg::result_t   out_result;

	hdx_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (text.valid),
		.in_ready     (text.ready),
		.in_character (text.character),
		.in_final_req (text.final_req),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.room         (room),
		.push         (push),
		.pair         (pair)
	);

	hdx_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pair       (pair),
		.room       (room),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_result (out_result)
	);

	assign result.data_byte = out_result.data_byte;
	assign result.status    = out_result.status;
	assign result.run_end   = out_result.run_end;

endmodule

/* hdl/hdx_parser.sv */
// ----------------------------------------------------------------------------
// hdx_parser
// Input register, configuration registers and the per-character dump line
// parser; produces up to two results per character.
// ----------------------------------------------------------------------------
module hdx_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     in_character,
	input  logic                           in_final_req,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hdx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdx_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           room,
	output logic                           push,
	output hdx_pkg::res_pair_t             pair
);

	logic                              valid_s1;
	logic [7:0]                        char_s1;
	logic                              final_s1;
	logic                              advance;

	logic [hdx_pkg::ADDR_W-1:0]        start_q, start_d;
	logic [hdx_pkg::BYTES_W-1:0]       eff_q, eff_d;
	logic [hdx_pkg::ADDR_W-1:0]        want_q, want_d;
	logic [hdx_pkg::BYTES_W-1:0]       emit_q, emit_d;
	hdx_pkg::phase_t                   ph_q, ph_d;
	logic [hdx_pkg::ADDR_W-1:0]        acc_q, acc_d;
	logic [hdx_pkg::DIGIT_CNT_W-1:0]   cnt_q, cnt_d;
	logic                              match_q, match_d;
	logic [7:0]                        held_q, held_d;
	logic [1:0]                        hc_q, hc_d;
	logic                              pz_q, pz_d;
	logic                              fin_q, fin_d;

	logic                              hex;
	logic [3:0]                        hv;
	logic                              gap;
	logic                              srch;
	logic                              pz_srch;
	logic                              take_now;
	logic                              take;
	logic [hdx_pkg::BYTES_W-1:0]       req_cnt;
	hdx_pkg::result_t                  res_byte;
	hdx_pkg::result_t                  res_nf;

	assign advance   = valid_s1 && room;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			final_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			char_s1  <= in_character;
			final_s1 <= in_final_req;
		end
	end

	// character classes
	always_comb begin
		hex = 1'b0;
		hv  = 4'd0;
		if (char_s1 inside {[8'h30:8'h39]}) begin
			hex = 1'b1;
			hv  = 4'(char_s1 - 8'h30);
		end else if (char_s1 inside {[8'h61:8'h66]}) begin
			hex = 1'b1;
			hv  = 4'(char_s1 - 8'h57);
		end else if (char_s1 inside {[8'h41:8'h46]}) begin
			hex = 1'b1;
			hv  = 4'(char_s1 - 8'h37);
		end
		gap = char_s1 inside {hdx_pkg::CH_SP, hdx_pkg::CH_TAB, hdx_pkg::CH_CR};
	end

	assign req_cnt = cfg_data[hdx_pkg::BYTES_W-1:0];

	always_comb begin
		start_d  = start_q;
		eff_d    = eff_q;
		want_d   = want_q;
		emit_d   = emit_q;
		ph_d     = ph_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		match_d  = match_q;
		held_d   = held_q;
		hc_d     = hc_q;
		pz_d     = pz_q;
		fin_d    = fin_q;
		srch     = 1'b0;
		pz_srch  = pz_q;
		take_now = 1'b0;
		take     = 1'b0;
		res_byte = '0;
		res_nf   = '0;
		pair     = '0;
		push     = 1'b0;

		if (cfg_valid) begin
			case (cfg_index)
				hdx_pkg::REG_START_ADDRESS: start_d = cfg_data[hdx_pkg::ADDR_W-1:0];
				hdx_pkg::REG_BYTE_COUNT: begin
					if (req_cnt == '0) begin
						eff_d = hdx_pkg::BYTES_W'(1);
					end else if (req_cnt > hdx_pkg::BYTES_W'(hdx_pkg::MAX_DUMP_BYTES)) begin
						eff_d = hdx_pkg::BYTES_W'(hdx_pkg::MAX_DUMP_BYTES);
					end else begin
						eff_d = req_cnt;
					end
				end
				default: start_d = start_q;
			endcase
			want_d  = start_d;
			emit_d  = '0;
			ph_d    = hdx_pkg::PH_SEARCH;
			acc_d   = '0;
			cnt_d   = '0;
			match_d = 1'b0;
			held_d  = '0;
			hc_d    = '0;
			pz_d    = 1'b0;
			fin_d   = 1'b0;
		end else if (advance) begin
			if (!fin_q) begin
				case (ph_q)
					hdx_pkg::PH_ADDR: begin
						if (hex) begin
							if (cnt_q >= hdx_pkg::DIGIT_CNT_W'(hdx_pkg::ADDR_DIGITS_MAX)) begin
								ph_d = hdx_pkg::PH_SEARCH;
							end else begin
								acc_d = {acc_q[hdx_pkg::ADDR_W-5:0], hv};
								cnt_d = cnt_q + 1'b1;
							end
							pz_d = (char_s1 == hdx_pkg::CH_ZERO);
						end else if (char_s1 == hdx_pkg::CH_COLON && cnt_q != '0) begin
							ph_d    = hdx_pkg::PH_LINE;
							match_d = (acc_q == want_q);
							hc_d    = '0;
							pz_d    = 1'b0;
						end else begin
							srch = 1'b1;
						end
					end
					hdx_pkg::PH_LINE: begin
						case (hc_q)
							2'd0: begin
								if (hex) begin
									held_d = {hv, 4'd0};
									hc_d   = 2'd1;
								end else if (!gap) begin
									ph_d = hdx_pkg::PH_SEARCH;
									pz_d = 1'b0;
								end
							end
							2'd1: begin
								if (hex) begin
									held_d = {held_q[7:4], hv};
									hc_d   = 2'd2;
								end else begin
									hc_d    = '0;
									srch    = 1'b1;
									pz_srch = (held_q[7:4] == 4'd0);
								end
							end
							default: begin
								if (gap || char_s1 == hdx_pkg::CH_NL) begin
									take_now = 1'b1;
									hc_d     = '0;
									if (char_s1 == hdx_pkg::CH_NL) begin
										ph_d = hdx_pkg::PH_SEARCH;
										pz_d = 1'b0;
									end
								end else begin
									hc_d    = '0;
									srch    = 1'b1;
									pz_srch = (held_q[3:0] == 4'd0);
								end
							end
						endcase
					end
					default: srch = 1'b1;
				endcase

				if (srch) begin
					if (pz_srch && char_s1 == hdx_pkg::CH_X) begin
						ph_d  = hdx_pkg::PH_ADDR;
						acc_d = '0;
						cnt_d = '0;
					end else begin
						ph_d = hdx_pkg::PH_SEARCH;
					end
					pz_d = (char_s1 == hdx_pkg::CH_ZERO);
				end

				// pending complete token at end of stream counts as delimited
				take = take_now ||
					(final_s1 && ph_d == hdx_pkg::PH_LINE && hc_d == 2'd2);

				if (take) begin
					hc_d = '0;
					if (match_q) begin
						want_d             = want_q + 1'b1;
						emit_d             = emit_q + 1'b1;
						res_byte.data_byte = held_d;
						if (emit_d >= eff_q) begin
							fin_d            = 1'b1;
							res_byte.status  = hdx_pkg::ST_LAST;
							res_byte.run_end = 1'b1;
						end else begin
							res_byte.status  = hdx_pkg::ST_BYTE;
							res_byte.run_end = 1'b0;
						end
						pair.first = res_byte;
						pair.num   = 2'd1;
					end
				end

				if (final_s1 && !fin_d) begin
					res_nf.data_byte = '0;
					res_nf.status    = hdx_pkg::ST_NOT_FOUND;
					res_nf.run_end   = 1'b1;
					if (pair.num == 2'd0) begin
						pair.first = res_nf;
					end else begin
						pair.second = res_nf;
					end
					pair.num = pair.num + 1'b1;
				end
			end

			push = (pair.num != 2'd0);

			if (final_s1) begin
				want_d  = start_q;
				emit_d  = '0;
				ph_d    = hdx_pkg::PH_SEARCH;
				acc_d   = '0;
				cnt_d   = '0;
				match_d = 1'b0;
				held_d  = '0;
				hc_d    = '0;
				pz_d    = 1'b0;
				fin_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			eff_q   <= hdx_pkg::BYTES_W'(1);
			want_q  <= '0;
			emit_q  <= '0;
			ph_q    <= hdx_pkg::PH_SEARCH;
			acc_q   <= '0;
			cnt_q   <= '0;
			match_q <= 1'b0;
			held_q  <= '0;
			hc_q    <= '0;
			pz_q    <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			start_q <= start_d;
			eff_q   <= eff_d;
			want_q  <= want_d;
			emit_q  <= emit_d;
			ph_q    <= ph_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			match_q <= match_d;
			held_q  <= held_d;
			hc_q    <= hc_d;
			pz_q    <= pz_d;
			fin_q   <= fin_d;
		end
	end

	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> emit_q == eff_q)
		else $error("finished run with byte count short of target");

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_q |-> emit_q < eff_q)
		else $error("open run reached its byte count");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != 2'd3 && cnt_q <= hdx_pkg::DIGIT_CNT_W'(hdx_pkg::ADDR_DIGITS_MAX))
		else $error("nibble or digit counter out of range");

endmodule

/* hdl/hdx_result_queue.sv */
// ----------------------------------------------------------------------------
// hdx_result_queue
// Two-entry queue of result pairs; hands out one result per transfer.
// ----------------------------------------------------------------------------
module hdx_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hdx_pkg::res_pair_t pair,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output hdx_pkg::result_t   out_result
);

	hdx_pkg::res_pair_t pair_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic               sub_q;
	logic               pop;
	logic               pop_entry;
	hdx_pkg::res_pair_t head;

	assign room       = (cnt_q != 2'd2);
	assign out_valid  = (cnt_q != 2'd0);
	assign head       = pair_q[rp_q];
	assign out_result = sub_q ? head.second : head.first;
	assign pop        = out_valid && out_ready;
	assign pop_entry  = pop && (sub_q || head.num == 2'd1);

	always_ff @(posedge clk) begin
		if (push) begin
			pair_q[wp_q] <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
			sub_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				sub_q <= !pop_entry;
			end
			if (pop_entry) begin
				rp_q <= !rp_q;
			end
			case ({push, pop_entry})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue over capacity");

	a_second_exists: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sub_q |-> head.num == 2'd2)
		else $error("second result read from a single-result entry");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push into a full result queue");

endmodule
